@@ hdl/sded_pkg.sv @@
// Shared constants and arithmetic helpers for the stereo damped echo delay.
// Depends on nothing; used by stereo_damped_echo_delay.
package sded_pkg;

  localparam int unsigned ADDR_W    = 16;               // log2 of line capacity
  localparam int unsigned LINE_W    = 20;               // stored line word width
  localparam int unsigned SUM_W     = 24;               // headroom for sums before saturation
  localparam int unsigned PROD_W    = 38;               // shared multiplier product width
  localparam int unsigned RND_W     = PROD_W - 15;      // product after Q15 rounding
  localparam int unsigned DVD_W     = 33;               // divider dividend / quotient width
  localparam int unsigned DVS_W     = 19;               // divider divisor width
  localparam int unsigned TAIL_W    = 19;
  localparam int unsigned DFQ_W     = 23;               // delay numerator after dropping /8
  localparam int unsigned RECIP_W   = 24;
  localparam int unsigned RECIP_SH  = 30;

  localparam logic [ADDR_W-1:0] DF_MAX = '1;            // capacity - 1
  localparam logic [DVD_W-1:0]  DF_ROUND = 33'd999;
  localparam logic [DVD_W-1:0]  DF_SAT_NUM = 33'd65535000; // (capacity - 1) * 1000
  localparam logic [RECIP_W-1:0] RECIP_125 = 24'd8589935;  // ceil(2^30 / 125)
  localparam logic [DVS_W-1:0]  DAMP_OMEGA = 19'd28274;
  localparam logic [DVD_W-1:0]  ALPHA_NUM = 33'd926482432; // 32768 * omega
  localparam logic [17:0]       FS_DEFAULT = 18'd44100;
  localparam logic [14:0]       FB_LIMIT = 15'd24576;

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_DELAY    = 3'd1;
  localparam logic [2:0] REG_RATE     = 3'd2;
  localparam logic [2:0] REG_WET      = 3'd3;
  localparam logic [2:0] REG_FB       = 3'd4;

  // Q15 product back to integer scale, rounding half up.
  function automatic logic signed [RND_W-1:0] rnd_q15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] s;
    s = (PROD_W+1)'(p) + (PROD_W+1)'(16384);
    return s[PROD_W-1:15];
  endfunction

  function automatic logic signed [LINE_W-1:0] sat_line(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (LINE_W - 1)) - 64'sd1);
    lo = -hi - SUM_W'(1);
    if (v > hi) return hi[LINE_W-1:0];
    if (v < lo) return lo[LINE_W-1:0];
    return v[LINE_W-1:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(32767)) return 16'sh7FFF;
    if (v < -SUM_W'(32768)) return 16'sh8000;
    return v[15:0];
  endfunction

  // Move a gain 1/64 of the way to its goal, at least one step.
  function automatic logic [14:0] glide(input logic [14:0] cur, input logic [14:0] goal);
    logic signed [15:0] delta;
    logic [15:0] mag;
    logic [15:0] st;
    delta = $signed({1'b0, goal}) - $signed({1'b0, cur});
    mag = delta[15] ? 16'(-delta) : 16'(delta);
    st = mag >> 6;
    if (st == 16'd0 && mag != 16'd0) st = 16'd1;
    return delta[15] ? 15'(cur - st[14:0]) : 15'(cur + st[14:0]);
  endfunction

endpackage

@@ hdl/stereo_damped_echo_delay.sv @@
// Stereo echo / delay with a one-pole damped feedback path, top level.
// Depends on sded_pkg for constants and saturating Q15 helpers.
//
//   channel   signals                                  role
//   input     in_valid, in_stall, in_left/right, engage   one PCM frame per transfer
//   output    out_valid, out_stall, out_left/right        one PCM frame per transfer
//   config    psel, penable, pwrite, paddr, pwdata, ...   APB-style register port
//
// A processed frame holds the input while it passes through one shared 22x16
// multiplier (setup, line read, then five steps per channel); a bypassed frame
// skips the line read and the multiplier steps.
// Reset, and any write of the delay time or the sample rate, start a recompute:
// the delay length by reciprocal multiplication, then the damping coefficient
// on a bit-serial divider; in_stall stays high until it ends.
// The line RAM is never swept: a write pointer plus a wrap flag mark which
// entries hold data since the last clear.
// A result waits in the output register; the next frame is taken meanwhile,
// and a frame that finishes while the output register is still full holds there.
module stereo_damped_echo_delay (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_left,
  input  logic signed [15:0]  in_right,
  input  logic                engage,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_left,
  output logic signed [15:0]  out_right
);

  typedef enum logic [3:0] {
    S_IDLE, S_CMUL, S_DFQ, S_DFSET, S_DIV, S_PREP, S_GLIDE, S_READ,
    S_MW, S_MA, S_DU, S_MF, S_WR, S_FIN
  } st_t;

  localparam int unsigned LW = sded_pkg::LINE_W;
  localparam int unsigned AW = sded_pkg::ADDR_W;
  localparam int unsigned RW = sded_pkg::DFQ_W + sded_pkg::RECIP_W;

  st_t st;

  // configuration
  logic        mode;
  logic [13:0] delay_time;
  logic [17:0] fs_rate;
  logic [14:0] wet_target;
  logic [14:0] fb_target;
  logic        dirty;

  // derived values
  logic [AW-1:0] df;
  logic [14:0]   alpha;

  // channel state
  logic [AW-1:0]          wp;
  logic                   wrapped;
  logic signed [LW-1:0]   damp_l, damp_r;
  logic [14:0]            wet_now, fb_now;
  logic [sded_pkg::TAIL_W-1:0] tail;
  logic                   was_eng;

  // frame in flight
  logic signed [15:0]     x_l, x_r;
  logic                   eng;
  logic                   ch;
  logic                   rd_ok;
  logic signed [LW-1:0]   dly_l, dly_r;
  logic signed [15:0]     res_l, res_r;

  // divider
  logic [sded_pkg::DVD_W-1:0] dvd, quo;
  logic [sded_pkg::DVS_W-1:0] dvs, rem;
  logic [5:0]                 cnt;

  // delay length by reciprocal multiplication
  logic [sded_pkg::DVD_W-1:0] df_num;
  logic                       df_sat;
  logic [RW-1:0]              df_prod;
  logic [AW:0]                df_q;

  // shared multiplier
  logic signed [21:0]                 mul_a;
  logic signed [15:0]                 mul_b;
  logic signed [sded_pkg::PROD_W-1:0] prod;

  // line RAM
  logic signed [LW-1:0] mem_l [2**AW];
  logic signed [LW-1:0] mem_r [2**AW];
  logic signed [LW-1:0] q_l, q_r;
  logic [AW-1:0]        rd;
  logic                 we;
  logic signed [LW-1:0] wdata;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic        cfg_dirty;
  logic        frozen;
  logic [14:0] fb_goal;
  logic        in_take;

  logic signed [LW-1:0]   dly_c, damp_c;
  logic signed [15:0]     x_c;
  logic signed [sded_pkg::RND_W-1:0] prod_r;
  logic [sded_pkg::DVS_W:0] rem_sh;
  logic [sded_pkg::DVS_W:0] rem_sub;
  logic [sded_pkg::TAIL_W-1:0] tail_load;
  logic [14:0] fb_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = paddr[4:2];
  assign cfg_dirty = cfg_wr && ((cfg_idx == sded_pkg::REG_RATE) ||
                                (cfg_idx == sded_pkg::REG_DELAY));
  assign frozen   = !was_eng && (tail != '0);
  assign fb_goal  = mode ? 15'd0 : fb_target;
  assign in_stall = (st != S_IDLE) || dirty;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    case (cfg_idx)
      sded_pkg::REG_MODE:     prdata = {31'd0, mode};
      sded_pkg::REG_DELAY:    prdata = {18'd0, delay_time};
      sded_pkg::REG_RATE:     prdata = {14'd0, fs_rate};
      sded_pkg::REG_WET:      prdata = {17'd0, wet_target};
      sded_pkg::REG_FB:       prdata = {17'd0, fb_target};
      default:                prdata = 32'd0;
    endcase
  end

  assign fb_wr = (pwdata[14:0] > sded_pkg::FB_LIMIT) ? sded_pkg::FB_LIMIT : pwdata[14:0];

  // per-channel selection
  assign dly_c  = ch ? dly_r : dly_l;
  assign damp_c = ch ? damp_r : damp_l;
  assign x_c    = ch ? x_r : x_l;
  assign prod_r = sded_pkg::rnd_q15(prod);

  always_comb begin
    case (st)
      S_CMUL: begin
        mul_a = $signed({4'd0, fs_rate});
        mul_b = $signed({2'd0, delay_time});
      end
      S_MW: begin
        mul_a = 22'(dly_c);
        mul_b = $signed({1'b0, wet_now});
      end
      S_MA: begin
        mul_a = 22'(dly_c) - 22'(damp_c);
        mul_b = $signed({1'b0, alpha});
      end
      S_MF: begin
        mul_a = 22'(damp_c);
        mul_b = $signed({1'b0, fb_now});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= sded_pkg::PROD_W'(mul_a) * sded_pkg::PROD_W'(mul_b);
  end

  // ceil(rate * ms / 1000): add 999, then divide by 8 and by 125 via reciprocal;
  // anything from the line size - 1 up is clamped to the largest delay after the multiply
  assign df_num = prod[sded_pkg::DVD_W-1:0] + sded_pkg::DF_ROUND;
  assign df_q   = df_prod[RW-1:sded_pkg::RECIP_SH];

  // restoring divider step
  assign rem_sh  = {rem, dvd[sded_pkg::DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  // read address and line write data
  assign rd    = wp - df;
  assign we    = (st == S_WR);
  assign wdata = sded_pkg::sat_line(eng ? sded_pkg::SUM_W'(x_c) + sded_pkg::SUM_W'(prod_r)
                                        : sded_pkg::SUM_W'(prod_r));

  always_ff @(posedge clk) begin
    if (st == S_GLIDE) begin
      q_l <= mem_l[rd];
    end
    if (we && !ch) begin
      mem_l[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_GLIDE) begin
      q_r <= mem_r[rd];
    end
    if (we && ch) begin
      mem_r[wp] <= wdata;
    end
  end

  assign tail_load = mode ? sded_pkg::TAIL_W'(df) : {fs_rate, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      mode        <= 1'b0;
      delay_time  <= 14'd250;
      fs_rate     <= 18'd44100;
      wet_target  <= 15'd16384;
      fb_target   <= 15'd12288;
      dirty       <= 1'b1;
      wp          <= '0;
      wrapped     <= 1'b0;
      damp_l      <= '0;
      damp_r      <= '0;
      wet_now     <= '0;
      fb_now      <= '0;
      tail        <= '0;
      was_eng     <= 1'b0;
      out_valid   <= 1'b0;
      ch          <= 1'b0;
      cnt         <= '0;
    end else begin
      // drop the result once the consumer takes it, unless a new one replaces it
      if (out_valid && !out_stall && (st != S_FIN)) begin
        out_valid <= 1'b0;
      end

      // hold the recompute request until the sequencer picks it up in idle
      dirty <= cfg_dirty || (dirty && (st != S_IDLE));

      // register writes; mode, delay and gain targets freeze while a tail rings
      if (cfg_wr) begin
        if (cfg_idx == sded_pkg::REG_RATE) begin
          fs_rate <= pwdata[17:0];
        end else if (!frozen) begin
          case (cfg_idx)
            sded_pkg::REG_MODE: begin
              mode <= pwdata[0];
              if (pwdata[0] != mode && was_eng) begin
                wp      <= '0;
                wrapped <= 1'b0;
                damp_l  <= '0;
                damp_r  <= '0;
                tail    <= '0;
                wet_now <= wet_target;
                fb_now  <= pwdata[0] ? 15'd0 : fb_target;
              end
            end
            sded_pkg::REG_DELAY: delay_time <= pwdata[13:0];
            sded_pkg::REG_WET: wet_target <= pwdata[14:0];
            sded_pkg::REG_FB:  fb_target  <= fb_wr;
            default: ;
          endcase
        end
      end

      case (st)
        S_IDLE: begin
          if (dirty) begin
            st    <= S_CMUL;
          end else if (in_take) begin
            x_l <= in_left;
            x_r <= in_right;
            eng <= engage;
            st  <= S_PREP;
          end
        end
        S_CMUL: begin
          // rate * ms lands in the product register next cycle
          st <= S_DFQ;
        end
        S_DFQ: begin
          df_sat  <= (df_num >= sded_pkg::DF_SAT_NUM);
          df_prod <= RW'(df_num[sded_pkg::DFQ_W+2:3]) * RW'(sded_pkg::RECIP_125);
          st      <= S_DFSET;
        end
        S_DFSET: begin
          if (df_sat || df_q[AW]) begin
            df <= sded_pkg::DF_MAX;
          end else if (df_q == '0) begin
            df <= AW'(1);
          end else begin
            df <= df_q[AW-1:0];
          end
          cnt <= '0;
          st  <= S_DIV;
        end
        S_DIV: begin
          // damping coefficient: 32768 * omega / (omega + rate)
          if (cnt == 6'd0) begin
            dvd <= sded_pkg::ALPHA_NUM;
            dvs <= sded_pkg::DAMP_OMEGA +
                   sded_pkg::DVS_W'((fs_rate != '0) ? fs_rate : sded_pkg::FS_DEFAULT);
            rem <= '0;
            quo <= '0;
            cnt <= 6'd1;
          end else if (cnt <= 6'(sded_pkg::DVD_W)) begin
            dvd <= dvd << 1;
            if (!rem_sub[sded_pkg::DVS_W]) begin
              rem <= rem_sub[sded_pkg::DVS_W-1:0];
              quo <= {quo[sded_pkg::DVD_W-2:0], 1'b1};
            end else begin
              rem <= rem_sh[sded_pkg::DVS_W-1:0];
              quo <= {quo[sded_pkg::DVD_W-2:0], 1'b0};
            end
            cnt <= cnt + 6'd1;
          end else begin
            cnt   <= '0;
            alpha <= quo[14:0];
            st    <= S_IDLE;
          end
        end
        S_PREP: begin
          was_eng <= eng;
          if (eng && !was_eng) begin
            // engage rise: empty the line and jump gains to their targets
            wp      <= '0;
            wrapped <= 1'b0;
            damp_l  <= '0;
            damp_r  <= '0;
            tail    <= '0;
            wet_now <= wet_target;
            fb_now  <= fb_goal;
            st      <= S_GLIDE;
          end else if (!eng && was_eng) begin
            tail <= tail_load;
            st   <= (tail_load == '0) ? S_FIN : S_GLIDE;
          end else begin
            st <= (!eng && tail == '0) ? S_FIN : S_GLIDE;
          end
          res_l <= x_l;
          res_r <= x_r;
        end
        S_GLIDE: begin
          wet_now <= sded_pkg::glide(wet_now, wet_target);
          fb_now  <= sded_pkg::glide(fb_now, fb_goal);
          rd_ok   <= wrapped || (rd < wp);
          ch      <= 1'b0;
          st      <= S_READ;
        end
        S_READ: begin
          // entries not written since the last clear read as zero
          dly_l <= rd_ok ? q_l : '0;
          dly_r <= rd_ok ? q_r : '0;
          st    <= S_MW;
        end
        S_MW: st <= S_MA;
        S_MA: begin
          if (ch) begin
            res_r <= sded_pkg::sat16(sded_pkg::SUM_W'(x_c) + sded_pkg::SUM_W'(prod_r));
          end else begin
            res_l <= sded_pkg::sat16(sded_pkg::SUM_W'(x_c) + sded_pkg::SUM_W'(prod_r));
          end
          st <= S_DU;
        end
        S_DU: begin
          if (ch) begin
            damp_r <= sded_pkg::sat_line(sded_pkg::SUM_W'(damp_c) + sded_pkg::SUM_W'(prod_r));
          end else begin
            damp_l <= sded_pkg::sat_line(sded_pkg::SUM_W'(damp_c) + sded_pkg::SUM_W'(prod_r));
          end
          st <= S_MF;
        end
        S_MF: st <= S_WR;
        S_WR: begin
          if (!ch) begin
            ch <= 1'b1;
            st <= S_MW;
          end else begin
            wp <= wp + AW'(1);
            if (wp == sded_pkg::DF_MAX) begin
              wrapped <= 1'b1;
            end
            if (!eng) begin
              tail <= tail - sded_pkg::TAIL_W'(1);
            end
            st <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_left  <= res_l;
            out_right <= res_r;
            out_valid <= 1'b1;
            st        <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule
